>>> rtl/core/divergent_slit_beam_intensity_assert.svh
// Assertion macros shared by the beam intensity RTL.
`ifndef DIVERGENT_SLIT_BEAM_INTENSITY_ASSERT_SVH
`define DIVERGENT_SLIT_BEAM_INTENSITY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSBI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beam intensity assertion failed");

// Next-cycle implication, checked out of reset.
`define DSBI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beam intensity assertion failed");

`endif

>>> rtl/core/dsbi_pkg.sv
`default_nettype none
package dsbi_pkg;

  // Erf values are Q1.28
  localparam int EQ = 28;
  localparam logic [28:0] ONE_EQ = 29'h1000_0000;

  // Quotient lanes: two erf arguments per axis
  localparam int LANES      = 4;
  localparam int LANE_HOR_A = 0;
  localparam int LANE_HOR_B = 1;
  localparam int LANE_VER_A = 2;
  localparam int LANE_VER_B = 3;

  // 32 quotient bits after a 22-bit head that must be zero
  localparam int DIV_STEPS  = 32;
  localparam int HEAD_SHIFT = 22;

  typedef enum logic [2:0] {
    REG_SLIT_DISTANCE,
    REG_TAN_HOR,
    REG_TAN_VER,
    REG_CENTRE_HOR,
    REG_CENTRE_UP,
    REG_SLIT_WIDTH,
    REG_SLIT_HEIGHT
  } reg_index_t;

  localparam logic [63:0] SQRT2_WIDE =
    (64'd141421356237 * 64'd16777216 + 64'd50000000000) / 64'd100000000000;
  localparam logic [24:0] SQRT2_FIX = SQRT2_WIDE[24:0];

  localparam logic [63:0] POLY_C0 =
    (64'd705230784 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] POLY_C1 =
    (64'd422820123 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] POLY_C2 =
    (64'd92705272 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] POLY_C3 =
    (64'd1520143 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] POLY_C4 =
    (64'd2765672 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] POLY_C5 =
    (64'd430638 * 64'h1000_0000 + 64'd5000000000) / 64'd10000000000;

  typedef struct packed {
    logic [31:0] slit_distance;
    logic [24:0] tan_hor;
    logic [24:0] tan_ver;
    logic [31:0] centre_hor;
    logic [31:0] centre_up;
    logic [30:0] slit_width;
    logic [30:0] slit_height;
  } cfg_t;

  // Flags that ride along with each point
  typedef struct packed {
    logic             upstream;
    logic             zero_h;
    logic             zero_v;
    logic             top_h;
    logic             top_v;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] sat;
  } side_t;

  typedef struct packed {
    logic [59:0] rem;
    logic        qbit;
  } div_res_t;

  // One restoring division step
  function automatic div_res_t div_step(logic [59:0] rem, logic [58:0] den);
    div_res_t    res;
    logic [59:0] r2;
    r2 = {rem[58:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      res.rem  = r2 - {1'b0, den};
      res.qbit = 1'b1;
    end else begin
      res.rem  = r2;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  // Shift-subtract quotient, used only while building the erf table
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // erf(4i/n) in Q1.28 from the rational approximation
  function automatic logic [28:0] erf_entry(logic [63:0] i, logic [63:0] n);
    logic [63:0] x;
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] r;
    x   = udiv64(i << 30, n);
    acc = POLY_C5;
    acc = ((acc * x) >> EQ) + POLY_C4;
    acc = ((acc * x) >> EQ) + POLY_C3;
    acc = ((acc * x) >> EQ) + POLY_C2;
    acc = ((acc * x) >> EQ) + POLY_C1;
    acc = ((acc * x) >> EQ) + POLY_C0;
    p   = ((acc * x) >> EQ) + 64'h1000_0000;
    r   = udiv64(64'd1 << 56, p);
    for (int k = 0; k < 4; k++) begin
      r = (r * r) >> EQ;
    end
    return 29'(64'h1000_0000 - r);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/divergent_slit_beam_intensity.sv
`default_nettype none
`include "divergent_slit_beam_intensity_assert.svh"
// Divergent slit beam intensity: takes one scattering point per clock while
// not stalled and returns the fraction of the beam that reaches it
// (Q1.RESULT_FRAC_BITS) plus an upstream flag; throughput is one point per
// cycle on the same terms. The pipeline depth comes mostly from the 32-stage
// restoring quotient pipeline that forms the erf arguments (4 front stages,
// 32 quotient stages, 3 table stages, 3 back stages). A stalled result
// freezes the whole pipeline; bubbles are not squeezed out while it waits.
// Configuration registers are written through write_enable / write_index /
// write_data and should only change while no point is in flight.
module divergent_slit_beam_intensity
  import dsbi_pkg::*;
#(
  parameter int RESULT_FRAC_BITS  = 16,
  parameter int ERF_TABLE_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [2:0]  write_index,
  input  wire logic [31:0] write_data,
  input  wire logic        point_valid,
  output logic             point_stall,
  input  wire logic [31:0] point_hor,
  input  wire logic [31:0] point_up,
  input  wire logic [31:0] point_beam,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [16:0]      intensity,
  output logic             upstream
);

  cfg_t                   cfg;
  logic                   adv;
  logic                   f_valid, d_valid;
  logic [LANES-1:0][59:0] f_rem;
  logic [58:0]            f_den_h, f_den_v;
  side_t                  f_side, d_side;
  logic [LANES-1:0][31:0] d_quot;
  logic [LANES-1:0][28:0] e_mag;
  logic                   e_valid [3];
  side_t                  e_side [3];

  // Advance the whole pipeline unless the result word is held
  assign adv         = !result_valid || !result_stall;
  assign point_stall = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_enable) begin
      unique case (reg_index_t'(write_index))
        REG_SLIT_DISTANCE: cfg.slit_distance <= write_data;
        REG_TAN_HOR:       cfg.tan_hor       <= write_data[24:0];
        REG_TAN_VER:       cfg.tan_ver       <= write_data[24:0];
        REG_CENTRE_HOR:    cfg.centre_hor    <= write_data;
        REG_CENTRE_UP:     cfg.centre_up     <= write_data;
        REG_SLIT_WIDTH:    cfg.slit_width    <= write_data[30:0];
        REG_SLIT_HEIGHT:   cfg.slit_height   <= write_data[30:0];
        default: ;
      endcase
    end
  end

  dsbi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (point_valid),
    .point_hor  (point_hor),
    .point_up   (point_up),
    .point_beam (point_beam),
    .cfg        (cfg),
    .out_valid  (f_valid),
    .rem        (f_rem),
    .den_h      (f_den_h),
    .den_v      (f_den_v),
    .side       (f_side)
  );

  dsbi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .rem_in    (f_rem),
    .den_h_in  (f_den_h),
    .den_v_in  (f_den_v),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_erf
    dsbi_erf #(
      .ERF_TABLE_ENTRIES (ERF_TABLE_ENTRIES)
    ) u_erf (
      .clk  (clk),
      .adv  (adv),
      .quot (d_quot[l]),
      .sat  (d_side.sat[l]),
      .mag  (e_mag[l])
    );
  end

  // Carry valid and flags alongside the table stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        e_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      e_valid[0] <= d_valid;
      e_valid[1] <= e_valid[0];
      e_valid[2] <= e_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side[0] <= d_side;
      e_side[1] <= e_side[0];
      e_side[2] <= e_side[1];
    end
  end

  dsbi_back #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (e_valid[2]),
    .mag       (e_mag),
    .side      (e_side[2]),
    .out_valid (result_valid),
    .intensity (intensity),
    .upstream  (upstream)
  );

  `DSBI_ASSERT_IMP(a_upstream_dark, clk, rst, result_valid && upstream, intensity == 17'd0)
  `DSBI_ASSERT_IMP(a_stall_cause, clk, rst, point_stall, result_valid && result_stall)
  `DSBI_ASSERT_NXT(a_hold, clk, rst, result_valid && result_stall, result_valid)

endmodule
`default_nettype wire

>>> rtl/core/dsbi_front.sv
`default_nettype none
module dsbi_front
  import dsbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic [31:0]            point_hor,
  input  wire logic [31:0]            point_up,
  input  wire logic [31:0]            point_beam,
  input  wire cfg_t                   cfg,
  output logic                        out_valid,
  output logic [LANES-1:0][59:0]      rem,
  output logic [58:0]                 den_h,
  output logic [58:0]                 den_v,
  output side_t                       side
);

  // Stage 1 registers
  logic        v1;
  logic [32:0] off_h1, off_v1, dist1;
  // Stage 2 registers
  logic              v2;
  logic [32:0]       sig_h2, sig_v2;
  logic [LANES-1:0][34:0] mag2;
  logic [LANES-1:0]  neg2;
  logic              top_h2, top_v2, up2;
  // Stage 3 registers
  logic              v3;
  logic [58:0]       den_h3, den_v3;
  logic [LANES-1:0][34:0] mag3;
  logic [LANES-1:0]  neg3;
  logic              top_h3, top_v3, up3, zero_h3, zero_v3;

  // Stage 2 combinational terms
  logic [56:0]       prod_h, prod_v;
  logic [34:0]       n [LANES];
  logic [32:0]       abs_h, abs_v;
  logic [33:0]       twice_h, twice_v;
  // Stage 3 combinational terms
  logic [57:0]       dprod_h, dprod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Offsets from the beam centre and distance past the slit
  always_ff @(posedge clk) begin
    if (adv) begin
      off_h1 <= {point_hor[31], point_hor} - {cfg.centre_hor[31], cfg.centre_hor};
      off_v1 <= {point_up[31], point_up} - {cfg.centre_up[31], cfg.centre_up};
      dist1  <= {point_beam[31], point_beam} +
                {cfg.slit_distance[31], cfg.slit_distance};
    end
  end

  // Sigma per axis and the signed edge terms 2*off +- width
  always_comb begin
    prod_h  = 57'(dist1[31:0]) * 57'(cfg.tan_hor);
    prod_v  = 57'(dist1[31:0]) * 57'(cfg.tan_ver);
    twice_h = {off_h1, 1'b0};
    twice_v = {off_v1, 1'b0};
    n[LANE_HOR_A] = {twice_h[33], twice_h} + {4'b0, cfg.slit_width};
    n[LANE_HOR_B] = {twice_h[33], twice_h} - {4'b0, cfg.slit_width};
    n[LANE_VER_A] = {twice_v[33], twice_v} + {4'b0, cfg.slit_height};
    n[LANE_VER_B] = {twice_v[33], twice_v} - {4'b0, cfg.slit_height};
    abs_h = off_h1[32] ? (33'd0 - off_h1) : off_h1;
    abs_v = off_v1[32] ? (33'd0 - off_v1) : off_v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sig_h2 <= prod_h[56:24];
      sig_v2 <= prod_v[56:24];
      for (int l = 0; l < LANES; l++) begin
        neg2[l] <= n[l][34];
        mag2[l] <= n[l][34] ? (35'd0 - n[l]) : n[l];
      end
      top_h2 <= {abs_h, 1'b0} <= {3'b0, cfg.slit_width};
      top_v2 <= {abs_v, 1'b0} <= {3'b0, cfg.slit_height};
      up2    <= dist1[32] || (dist1 == 33'd0);
    end
  end

  // Divisor 2*sqrt2*sigma
  always_comb begin
    dprod_h = 58'(sig_h2) * 58'(SQRT2_FIX);
    dprod_v = 58'(sig_v2) * 58'(SQRT2_FIX);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_h3  <= {dprod_h, 1'b0};
      den_v3  <= {dprod_v, 1'b0};
      zero_h3 <= (sig_h2 == 33'd0);
      zero_v3 <= (sig_v2 == 33'd0);
      mag3    <= mag2;
      neg3    <= neg2;
      top_h3  <= top_h2;
      top_v3  <= top_v2;
      up3     <= up2;
    end
  end

  // Saturation test on the quotient head and the first remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      den_h <= den_h3;
      den_v <= den_v3;
      for (int l = 0; l < LANES; l++) begin
        rem[l] <= {3'b0, mag3[l], {HEAD_SHIFT{1'b0}}};
        if (l == LANE_HOR_A || l == LANE_HOR_B) begin
          side.sat[l] <= {2'b0, mag3[l], {HEAD_SHIFT{1'b0}}} >= den_h3;
        end else begin
          side.sat[l] <= {2'b0, mag3[l], {HEAD_SHIFT{1'b0}}} >= den_v3;
        end
      end
      side.neg      <= neg3;
      side.upstream <= up3;
      side.zero_h   <= zero_h3;
      side.zero_v   <= zero_v3;
      side.top_h    <= top_h3;
      side.top_v    <= top_v3;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dsbi_div.sv
`default_nettype none
module dsbi_div
  import dsbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic [LANES-1:0][59:0] rem_in,
  input  wire logic [58:0]            den_h_in,
  input  wire logic [58:0]            den_v_in,
  input  wire side_t                  side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][31:0]      quot,
  output side_t                       side_out
);

  logic                   vld  [DIV_STEPS+1];
  logic [LANES-1:0][59:0] rem  [DIV_STEPS+1];
  logic [LANES-1:0][31:0] qacc [DIV_STEPS+1];
  logic [58:0]            den_h [DIV_STEPS+1];
  logic [58:0]            den_v [DIV_STEPS+1];
  side_t                  side [DIV_STEPS+1];
  div_res_t               step [DIV_STEPS][LANES];

  assign vld[0]   = in_valid;
  assign rem[0]   = rem_in;
  assign qacc[0]  = '0;
  assign den_h[0] = den_h_in;
  assign den_v[0] = den_v_in;
  assign side[0]  = side_in;

  // One quotient bit per stage on every lane
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (l == LANE_HOR_A || l == LANE_HOR_B) begin
          step[s][l] = div_step(rem[s][l], den_h[s]);
        end else begin
          step[s][l] = div_step(rem[s][l], den_v[s]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          rem[s+1][l]  <= step[s][l].rem;
          qacc[s+1][l] <= {qacc[s][l][30:0], step[s][l].qbit};
        end
        den_h[s+1] <= den_h[s];
        den_v[s+1] <= den_v[s];
        side[s+1]  <= side[s];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign quot      = qacc[DIV_STEPS];
  assign side_out  = side[DIV_STEPS];

endmodule
`default_nettype wire

>>> rtl/core/dsbi_erf.sv
`default_nettype none
module dsbi_erf
  import dsbi_pkg::*;
#(
  parameter int ERF_TABLE_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [31:0] quot,
  input  wire logic        sat,
  output logic [28:0]      mag
);

  localparam int AW = $clog2(ERF_TABLE_ENTRIES + 1);
  localparam int PW = 32 + AW;

  typedef logic [28:0] tab_t [ERF_TABLE_ENTRIES+1];

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i <= ERF_TABLE_ENTRIES; i++) begin
      t[i] = erf_entry(64'(i), 64'(ERF_TABLE_ENTRIES));
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();
  localparam logic [28:0] TAB_LAST = TAB[ERF_TABLE_ENTRIES];

  logic [PW-1:0] pos;
  logic [AW-1:0] idx1;
  logic [15:0]   frac1, frac2;
  logic          sat1, sat2;
  logic [28:0]   lo2, hi2;
  logic [28:0]   span;
  logic [44:0]   step_prod;

  // Table position: quotient times table length
  assign pos = PW'(quot) * PW'(ERF_TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1  <= pos[32 +: AW];
      frac1 <= pos[31:16];
      sat1  <= sat;
    end
  end

  // Fetch both neighbors
  always_ff @(posedge clk) begin
    if (adv) begin
      lo2   <= TAB[idx1];
      hi2   <= TAB[idx1 + AW'(1)];
      frac2 <= frac1;
      sat2  <= sat1;
    end
  end

  // Interpolate linearly, truncating
  always_comb begin
    span      = (hi2 >= lo2) ? (hi2 - lo2) : (lo2 - hi2);
    step_prod = 45'(span) * 45'(frac2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sat2) begin
        mag <= TAB_LAST;
      end else if (hi2 >= lo2) begin
        mag <= lo2 + step_prod[44:16];
      end else begin
        mag <= lo2 - step_prod[44:16];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dsbi_back.sv
`default_nettype none
`include "divergent_slit_beam_intensity_assert.svh"
module dsbi_back
  import dsbi_pkg::*;
#(
  parameter int RESULT_FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic [LANES-1:0][28:0] mag,
  input  wire side_t                  side,
  output logic                        out_valid,
  output logic [16:0]                 intensity,
  output logic                        upstream
);

  localparam int SFT = 2 * EQ - RESULT_FRAC_BITS;

  logic        v1, v2;
  logic [28:0] fh, fv;
  logic        up1, up2;
  logic [57:0] prod;
  logic [65:0] sum;

  // Half the erf difference, clamped at zero, or the top hat
  function automatic logic [28:0] axis_factor(logic [28:0] ma, logic [28:0] mb,
                                              logic na, logic nb,
                                              logic zero, logic top);
    logic signed [30:0] ea;
    logic signed [30:0] eb;
    logic signed [30:0] diff;
    ea   = na ? -$signed({2'b0, ma}) : $signed({2'b0, ma});
    eb   = nb ? -$signed({2'b0, mb}) : $signed({2'b0, mb});
    diff = ea - eb;
    if (zero) begin
      return top ? ONE_EQ : 29'd0;
    end
    if (diff[30]) begin
      return 29'd0;
    end
    return diff[29:1];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fh  <= axis_factor(mag[LANE_HOR_A], mag[LANE_HOR_B], side.neg[LANE_HOR_A],
                         side.neg[LANE_HOR_B], side.zero_h, side.top_h);
      fv  <= axis_factor(mag[LANE_VER_A], mag[LANE_VER_B], side.neg[LANE_VER_A],
                         side.neg[LANE_VER_B], side.zero_v, side.top_v);
      up1 <= side.upstream;
    end
  end

  // Product of the two axis factors
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 58'(fh) * 58'(fv);
      up2  <= up1;
    end
  end

  // Round half up to the result scale
  assign sum = 66'(prod) + (66'(1) << (SFT - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      intensity <= up2 ? 17'd0 : sum[SFT +: 17];
      upstream  <= up2;
    end
  end

  `DSBI_ASSERT_IMP(a_fh_max, clk, rst, v2, fh <= ONE_EQ)
  `DSBI_ASSERT_IMP(a_fv_max, clk, rst, v2, fv <= ONE_EQ)

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dsbi_pkg::*;

  localparam int  TAB_N     = 1024;
  localparam int  LIMIT     = 600000;
  localparam int  TAIL      = 60;
  localparam longint unsigned ONE_Q28 = 64'd1 << 28;

  typedef struct packed {
    logic [16:0] inten;
    logic        up;
  } lit_t;

  typedef struct {
    logic [31:0] hor;
    logic [31:0] up;
    logic [31:0] beam;
    bit          typed;
    logic [16:0] inten;
    logic        upf;
  } row_t;

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [2:0]  write_index;
  logic [31:0] write_data;
  logic        point_valid;
  logic        point_stall;
  logic [31:0] point_hor;
  logic [31:0] point_up;
  logic [31:0] point_beam;
  logic        result_valid;
  logic        result_stall;
  logic [16:0] intensity;
  logic        upstream;

  divergent_slit_beam_intensity u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_hor    (point_hor),
    .point_up     (point_up),
    .point_beam   (point_beam),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .intensity    (intensity),
    .upstream     (upstream)
  );

  // Shadow registers
  longint          sh_dist, sh_ch, sh_cu;
  longint unsigned sh_tan_h, sh_tan_v, sh_w, sh_h;

  longint unsigned erf_lut [TAB_N+1];
  longint unsigned poly_c [6];

  lit_t        lit_q [$];
  int          errors;
  int          taken;
  int          words_out;
  int          upstream_seen;
  int          cycles;
  bit          cur_typed;
  lit_t        cur_lit;
  int          burst_left;
  int          stall_mode;
  int          stall_left;

  // Build the erf lookup from the rational approximation
  function automatic void build_erf_lut();
    longint unsigned x, acc, p, r;
    poly_c[0] = (64'd705230784 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    poly_c[1] = (64'd422820123 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    poly_c[2] = (64'd92705272 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    poly_c[3] = (64'd1520143 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    poly_c[4] = (64'd2765672 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    poly_c[5] = (64'd430638 * ONE_Q28 + 64'd5000000000) / 64'd10000000000;
    for (int i = 0; i <= TAB_N; i++) begin
      x = (longint'(i) << 30) / TAB_N;
      acc = poly_c[5];
      for (int k = 4; k >= 0; k--) acc = ((acc * x) >> 28) + poly_c[k];
      p = ((acc * x) >> 28) + ONE_Q28;
      r = (64'd1 << 56) / p;
      for (int k = 0; k < 4; k++) r = (r * r) >> 28;
      erf_lut[i] = ONE_Q28 - r;
    end
  endfunction

  // erf of a*2^24/den, Q28
  function automatic longint unsigned erf_of_ratio(longint unsigned a, longint unsigned den);
    longint unsigned q, r, pos, idx, frac, lo, hi;
    q = 0;
    r = a;
    if (a >= den) return erf_lut[TAB_N];
    for (int i = 0; i < 54; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    if (q >= (64'd4 << 30)) return erf_lut[TAB_N];
    pos = (q * TAB_N) >> 2;
    idx = pos >> 30;
    if (idx >= TAB_N) return erf_lut[TAB_N];
    frac = (pos >> 14) & 64'hFFFF;
    lo = erf_lut[idx];
    hi = erf_lut[idx+1];
    if (hi >= lo) return lo + (((hi - lo) * frac) >> 16);
    return lo - (((lo - hi) * frac) >> 16);
  endfunction

  function automatic longint erf_signed_arg(longint n, longint unsigned den);
    if (n < 0) return -longint'(erf_of_ratio(longint'(0) - n, den));
    return longint'(erf_of_ratio(n, den));
  endfunction

  // Transmission along one transverse axis, Q28
  function automatic longint unsigned slit_factor(longint off, longint unsigned w,
                                                  longint unsigned sigma);
    longint unsigned mag, den;
    longint          diff;
    longint unsigned sqrt2q;
    sqrt2q = (64'd141421356237 * 64'd16777216 + 64'd50000000000) / 64'd100000000000;
    if (sigma == 0) begin
      mag = (off < 0) ? longint'(0) - off : off;
      return (2 * mag <= w) ? ONE_Q28 : 0;
    end
    den = sigma * sqrt2q * 2;
    diff = erf_signed_arg(2 * off + longint'(w), den) - erf_signed_arg(2 * off - longint'(w), den);
    if (diff < 0) diff = 0;
    if (diff > longint'(2 * ONE_Q28)) diff = 2 * ONE_Q28;
    return longint'(diff) >> 1;
  endfunction

  function automatic lit_t beam_fraction(logic [31:0] h, logic [31:0] u, logic [31:0] b);
    lit_t            res;
    longint          reach;
    longint unsigned sg_h, sg_v, fh, fv, prod;
    reach = longint'($signed(b)) + sh_dist;
    if (reach <= 0) begin
      res.inten = '0;
      res.up    = 1'b1;
      return res;
    end
    sg_h = (longint'(reach) * sh_tan_h) >> 24;
    sg_v = (longint'(reach) * sh_tan_v) >> 24;
    fh = slit_factor(longint'($signed(h)) - sh_ch, sh_w, sg_h);
    fv = slit_factor(longint'($signed(u)) - sh_cu, sh_h, sg_v);
    prod = fh * fv;
    prod = (prod + (64'd1 << 39)) >> 40;
    res.inten = prod[16:0];
    res.up    = 1'b0;
    return res;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("divergent_slit_beam_intensity regression: fail");
      $finish;
    end
  end

  // Record each accepted word with its expectation
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall) begin
      taken <= taken + 1;
      if (cur_typed) lit_q.push_back(cur_lit);
      else lit_q.push_back(beam_fraction(point_hor, point_up, point_beam));
    end
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    lit_t want;
    int   bad;
    bad = 0;
    if (!rst && result_valid && !result_stall) begin
      words_out <= words_out + 1;
      if (upstream) upstream_seen <= upstream_seen + 1;
      if (lit_q.size() == 0) begin
        $error("result word with nothing expected: intensity %0d upstream %0b",
               intensity, upstream);
        bad = bad + 1;
      end else begin
        want = lit_q.pop_front();
        if (intensity !== want.inten) begin
          $error("intensity expected %0d actual %0d", want.inten, intensity);
          bad = bad + 1;
        end
        if (upstream !== want.up) begin
          $error("upstream expected %0b actual %0b", want.up, upstream);
          bad = bad + 1;
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

  // Receiver stall pattern: switch among modes at random intervals
  always @(negedge clk) begin
    if (rst) begin
      result_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
        0: result_stall = 1'b0;
        1: result_stall = ($urandom_range(0, 3) == 0);
        2: result_stall = ($urandom_range(0, 3) != 0);
        default: result_stall = (cycles % 8) < 3;
      endcase
    end
  end

  task automatic set_reg(reg_index_t idx, logic [31:0] v);
    write_enable = 1'b1;
    write_index  = idx;
    write_data   = v;
    case (idx)
      REG_SLIT_DISTANCE: sh_dist  = longint'($signed(v));
      REG_TAN_HOR:       sh_tan_h = v[24:0];
      REG_TAN_VER:       sh_tan_v = v[24:0];
      REG_CENTRE_HOR:    sh_ch    = longint'($signed(v));
      REG_CENTRE_UP:     sh_cu    = longint'($signed(v));
      REG_SLIT_WIDTH:    sh_w     = v[30:0];
      default:           sh_h     = v[30:0];
    endcase
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic load_cfg(logic [31:0] d, logic [31:0] th, logic [31:0] tv, logic [31:0] ch,
                          logic [31:0] cu, logic [31:0] w, logic [31:0] h);
    set_reg(REG_SLIT_DISTANCE, d);
    set_reg(REG_TAN_HOR, th);
    set_reg(REG_TAN_VER, tv);
    set_reg(REG_CENTRE_HOR, ch);
    set_reg(REG_CENTRE_UP, cu);
    set_reg(REG_SLIT_WIDTH, w);
    set_reg(REG_SLIT_HEIGHT, h);
  endtask

  // Hold until every result is out, then let the pipe drain
  task automatic drain();
    point_valid = 1'b0;
    while (lit_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic send_point(logic [31:0] h, logic [31:0] u, logic [31:0] b, bit typed,
                            lit_t lit);
    int n0;
    if (burst_left == 0) begin
      point_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
    end
    burst_left  = burst_left - 1;
    point_hor   = h;
    point_up    = u;
    point_beam  = b;
    cur_typed   = typed;
    cur_lit     = lit;
    point_valid = 1'b1;
    n0 = taken;
    do @(negedge clk); while (taken == n0);
    point_valid = 1'b0;
    cur_typed   = 1'b0;
  endtask

  // Random point: mostly inside the lit region, some upstream, some noise
  task automatic send_random();
    int          mode;
    logic [31:0] h, u, b, off_h, off_u;
    lit_t        none;
    none = '0;
    mode = $urandom_range(0, 9);
    off_h = $signed($urandom) >>> $urandom_range(2, 30);
    off_u = $signed($urandom) >>> $urandom_range(2, 30);
    h = 32'(sh_ch) + off_h;
    u = 32'(sh_cu) + off_u;
    b = 32'(-sh_dist) + ($urandom >> $urandom_range(4, 31));
    if (mode == 0) begin
      h = $urandom;
      u = $urandom;
      b = $urandom;
    end else if (mode == 1) begin
      b = 32'(-sh_dist) - ($urandom >> $urandom_range(4, 31));
    end
    send_point(h, u, b, 1'b0, none);
  endtask

  task automatic random_cfg();
    logic [31:0] th, tv;
    th = $urandom >> $urandom_range(7, 20);
    tv = $urandom >> $urandom_range(7, 20);
    if ($urandom_range(0, 5) == 0) th = 0;
    if ($urandom_range(0, 5) == 0) tv = 32'h1FF_FFFF;
    load_cfg($urandom >> $urandom_range(3, 8), th, tv,
             $signed($urandom) >>> $urandom_range(4, 12),
             $signed($urandom) >>> $urandom_range(4, 12),
             ($urandom_range(0, 7) == 0) ? 32'd0 : ($urandom >> $urandom_range(4, 12)),
             $urandom >> $urandom_range(4, 12));
  endtask

  row_t reset_rows [] = '{
    '{32'h0, 32'h0, 32'h0, 1, 17'd0, 1'b1},
    '{32'h0, 32'h0, 32'h8000_0000, 1, 17'd0, 1'b1},
    '{32'h0, 32'h0, 32'h1, 1, 17'd65536, 1'b0},
    '{32'h0, 32'h0, 32'h7FFF_FFFF, 1, 17'd65536, 1'b0},
    '{32'h1, 32'h0, 32'h1, 1, 17'd0, 1'b0},
    '{32'h0, 32'hFFFF_FFFF, 32'h100, 1, 17'd0, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1000, 1, 17'd0, 1'b0}
  };

  row_t lit_rows [] = '{
    '{32'h0, 32'h0, 32'hFF00_0000, 1, 17'd0, 1'b1},
    '{32'h0, 32'h0, 32'h0, 0, 17'd0, 1'b0},
    '{32'h0008_0000, 32'h0, 32'h0, 0, 17'd0, 1'b0},
    '{32'hFFF8_0000, 32'h0010_0000, 32'h0100_0000, 0, 17'd0, 1'b0},
    '{32'h0100_0000, 32'h0, 32'h0, 0, 17'd0, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 17'd0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 17'd0, 1'b0},
    '{32'h0, 32'h0, 32'hFF00_0001, 0, 17'd0, 1'b0},
    '{32'h0004_0000, 32'hFFF0_0000, 32'h0400_0000, 0, 17'd0, 1'b0}
  };

  task automatic run_rows(row_t rows []);
    lit_t lit;
    foreach (rows[i]) begin
      lit.inten = rows[i].inten;
      lit.up    = rows[i].upf;
      send_point(rows[i].hor, rows[i].up, rows[i].beam, rows[i].typed, lit);
    end
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    write_index  = '0;
    write_data   = '0;
    point_valid  = 1'b0;
    point_hor    = '0;
    point_up     = '0;
    point_beam   = '0;
    result_stall = 1'b0;
    cur_typed    = 1'b0;
    cur_lit      = '0;
    errors = 0;
    taken = 0;
    words_out = 0;
    upstream_seen = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    sh_dist = 0; sh_ch = 0; sh_cu = 0;
    sh_tan_h = 0; sh_tan_v = 0; sh_w = 0; sh_h = 0;
    build_erf_lut();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset settings: no divergence, closed slit
    run_rows(reset_rows);
    drain();

    // Moderate beam: 1 m slit, narrow divergence
    load_cfg(32'h0100_0000, 32'h0000_4000, 32'h0001_0000, 32'h0, 32'h0,
             32'h0010_0000, 32'h0020_0000);
    run_rows(lit_rows);
    drain();

    // Zero width with nonzero sigma, tangent above one
    load_cfg(32'h0100_0000, 32'h1FF_FFFF, 32'h0100_0001, 32'h0, 32'h0, 32'h0, 32'h0040_0000);
    run_rows(lit_rows);
    drain();

    // Register extremes
    load_cfg(32'h7FFF_FFFF, 32'h1FF_FFFF, 32'h1FF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (100) send_random();
    drain();
    load_cfg(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    repeat (100) send_random();
    drain();

    // Random settings, one per phase
    for (int ph = 0; ph < 8; ph++) begin
      random_cfg();
      repeat (210) send_random();
      drain();
    end

    $display("covered %0d points, %0d results (%0d upstream) over 13 register settings",
             taken, words_out, upstream_seen);
    $display("sender bursts and receiver stall modes varied throughout");
    if (errors == 0 && lit_q.size() == 0) begin
      $display("divergent_slit_beam_intensity regression: pass");
    end else begin
      $display("divergent_slit_beam_intensity regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dsbi_pkg.sv
rtl/core/dsbi_front.sv
rtl/core/dsbi_div.sv
rtl/core/dsbi_erf.sv
rtl/core/dsbi_back.sv
rtl/core/divergent_slit_beam_intensity.sv
tb/sv/tb_top.sv
